// ----- hw/rtl/jpei_pkg.sv -----
// jpei_pkg: request and status codes, queued command type and back-end states
// for the journal page extent index; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jpei_pkg;

    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_APPLY  = 2'd1;
    localparam logic [1:0] REQ_ERASE  = 2'd2;
    localparam logic [1:0] REQ_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [47:0] seq;
        logic [47:0] prev;
        logic [31:0] from;
        logic [15:0] span;
        logic [31:0] jpage;
        logic        rend;
        logic [32:0] to;
        logic        bad;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AP_COUNT,
        S_AP_CLEAR,
        S_AP_SPLIT,
        S_AP_INSERT,
        S_ER_SCAN,
        S_LK_SCAN,
        S_LK_ROUND,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jpei_front.sv -----
// jpei_front: accepts request transactions, precomputes range end and range check,
// and queues them in a two-entry fifo; uses jpei_pkg
`timescale 1ns / 1ps
`default_nettype none

module jpei_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     req_type,
    input  wire logic [47:0]    seq_num,
    input  wire logic [47:0]    prev_seq_num,
    input  wire logic [31:0]    page_start,
    input  wire logic [15:0]    page_span,
    input  wire logic [31:0]    journal_page,
    input  wire logic           record_end,
    output logic                q_valid,
    output jpei_pkg::cmd_t      q_cmd,
    input  wire logic           q_pop
);

    jpei_pkg::cmd_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    jpei_pkg::cmd_t new_cmd;
    logic           push;

    always_comb
    begin
        new_cmd.req   = req_type;
        new_cmd.seq   = seq_num;
        new_cmd.prev  = prev_seq_num;
        new_cmd.from  = page_start;
        new_cmd.span  = page_span;
        new_cmd.jpage = journal_page;
        new_cmd.rend  = record_end;
        new_cmd.to    = {1'b0, page_start} + {17'd0, page_span};
        // end beyond the 2^32 page space
        new_cmd.bad   = new_cmd.to[32] && (new_cmd.to[31:0] != 32'd0);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/jpei_back.sv -----
// jpei_back: extent table, record tracking and the slot-scan sequencer that
// carries out queued requests and drives the result register; uses jpei_pkg
`timescale 1ns / 1ps
`default_nettype none

module jpei_back #(
    parameter int TABLE_SLOTS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  jpei_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          status,
    output logic                hit,
    output logic [31:0]         hit_page,
    output logic [31:0]         hit_journal_page,
    output logic [15:0]         hit_span,
    output logic [47:0]         indexed_seq_num,
    output logic                run_last
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(2 * TABLE_SLOTS + 2);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_SLOTS - 1);

    // extent table
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] slot_page    [TABLE_SLOTS];
    logic [15:0] slot_span    [TABLE_SLOTS];
    logic [31:0] slot_journal [TABLE_SLOTS];
    logic [47:0] slot_seq     [TABLE_SLOTS];
    logic          tw_en;
    logic [IW-1:0] tw_idx;
    logic [31:0]   tw_page, tw_journal;
    logic [15:0]   tw_span;
    logic [47:0]   tw_seq;

    jpei_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    jpei_pkg::cmd_t   cmd_reg, cmd_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    need_reg, need_next;
    logic [47:0]      iseq_reg, iseq_next;
    logic             inside_reg, inside_next, acc_reg, acc_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic        res_hit_reg, res_hit_next, res_last_reg, res_last_next;
    logic [31:0] res_page_reg, res_page_next, res_journal_reg, res_journal_next;
    logic [15:0] res_span_reg, res_span_next;

    logic        ov_reg, ov_next;
    logic [1:0]  os_reg, os_next;
    logic        oh_reg, oh_next, ol_reg, ol_next;
    logic [31:0] op_reg, op_next, oj_reg, oj_next;
    logic [15:0] osp_reg, osp_next;
    logic [47:0] oi_reg, oi_next;

    logic [31:0] sp_page_reg, sp_page_next, sp_journal_reg, sp_journal_next;
    logic [15:0] sp_span_reg, sp_span_next;
    logic [47:0] sp_seq_reg, sp_seq_next;
    logic        sp_last_reg, sp_last_next;

    logic        found_reg, found_next, have_last_reg, have_last_next;
    logic [31:0] last_pg_reg, last_pg_next;
    logic [31:0] best_page_reg, best_page_next, best_journal_reg, best_journal_next;
    logic [15:0] best_span_reg, best_span_next;
    logic        pend_reg, pend_next;
    logic [31:0] pend_page_reg, pend_page_next, pend_journal_reg, pend_journal_next;
    logic [15:0] pend_span_reg, pend_span_next;

    logic [31:0] rd_page, rd_journal;
    logic [15:0] rd_span;
    logic [47:0] rd_seq;
    logic [32:0] es, ee, from33;
    logic        rd_valid, ovl, left_part, right_part, cand, acc_now;
    logic [IW-1:0] free_idx;
    logic [CW-1:0] need_inc;
    logic [32:0] best_end, cf, ct;

    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        rd_valid   = valid_reg[idx_reg];
        rd_page    = slot_page[idx_reg];
        rd_span    = slot_span[idx_reg];
        rd_journal = slot_journal[idx_reg];
        rd_seq     = slot_seq[idx_reg];
        from33     = {1'b0, cmd_reg.from};
        es         = {1'b0, rd_page};
        ee         = es + {17'd0, rd_span};
        ovl        = !((es >= cmd_reg.to) || (ee <= from33));
        left_part  = es < from33;
        right_part = ee > cmd_reg.to;
        cand       = rd_valid && (rd_seq > cmd_reg.seq) && ovl
                     && (!have_last_reg || (rd_page > last_pg_reg))
                     && (!found_reg || (rd_page < best_page_reg));
        need_inc   = ovl ? (CW'(left_part) + CW'(right_part)) : CW'(1);
        best_end   = {1'b0, best_page_reg} + {17'd0, best_span_reg};
        cf         = (best_page_reg > cmd_reg.from) ? {1'b0, best_page_reg} : from33;
        ct         = (best_end < cmd_reg.to) ? best_end : cmd_reg.to;
        acc_now    = inside_reg ? acc_reg : (q_cmd.prev == iseq_reg);
    end

    always_comb
    begin
        state_next = state_reg;   ret_next = ret_reg;
        cmd_next = cmd_reg;       idx_next = idx_reg;     need_next = need_reg;
        iseq_next = iseq_reg;     inside_next = inside_reg; acc_next = acc_reg;
        res_status_next = res_status_reg; res_hit_next = res_hit_reg;
        res_last_next = res_last_reg;     res_page_next = res_page_reg;
        res_journal_next = res_journal_reg; res_span_next = res_span_reg;
        sp_page_next = sp_page_reg; sp_journal_next = sp_journal_reg;
        sp_span_next = sp_span_reg; sp_seq_next = sp_seq_reg; sp_last_next = sp_last_reg;
        found_next = found_reg;   have_last_next = have_last_reg;
        last_pg_next = last_pg_reg;
        best_page_next = best_page_reg; best_journal_next = best_journal_reg;
        best_span_next = best_span_reg;
        pend_next = pend_reg;     pend_page_next = pend_page_reg;
        pend_journal_next = pend_journal_reg; pend_span_next = pend_span_reg;
        valid_next = valid_reg;
        tw_en = 1'b0; tw_idx = idx_reg; tw_page = '0; tw_span = '0;
        tw_journal = '0; tw_seq = '0;
        q_pop = 1'b0;
        ov_next = ov_reg && !out_ready;
        os_next = os_reg; oh_next = oh_reg; ol_next = ol_reg; op_next = op_reg;
        oj_next = oj_reg; osp_next = osp_reg; oi_next = oi_reg;

        unique case (state_reg)
            jpei_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    idx_next = '0;
                    res_status_next = jpei_pkg::ST_OK;
                    res_hit_next = 1'b0; res_last_next = 1'b1;
                    res_page_next = '0; res_journal_next = '0; res_span_next = '0;
                    ret_next = jpei_pkg::S_IDLE;
                    state_next = jpei_pkg::S_EMIT;
                    unique case (q_cmd.req)
                        jpei_pkg::REQ_SET:
                        begin
                            iseq_next = q_cmd.seq;
                        end
                        jpei_pkg::REQ_APPLY:
                        begin
                            if (!acc_now)
                                res_status_next = jpei_pkg::ST_REJECTED;
                            else if (q_cmd.span == 16'd0)
                                res_status_next = jpei_pkg::ST_OK;
                            else if (q_cmd.bad)
                                res_status_next = jpei_pkg::ST_BAD;
                            else
                            begin
                                need_next = CW'(1);
                                state_next = jpei_pkg::S_AP_COUNT;
                            end
                            // record tracking does not depend on the table work
                            if (q_cmd.rend)
                            begin
                                if (acc_now)
                                    iseq_next = q_cmd.seq;
                                inside_next = 1'b0;
                                acc_next = 1'b0;
                            end
                            else
                            begin
                                inside_next = 1'b1;
                                acc_next = acc_now;
                            end
                        end
                        jpei_pkg::REQ_ERASE:
                        begin
                            state_next = jpei_pkg::S_ER_SCAN;
                        end
                        default:
                        begin
                            if ((q_cmd.seq < iseq_reg) && (q_cmd.span != 16'd0))
                            begin
                                found_next = 1'b0;
                                have_last_next = 1'b0;
                                pend_next = 1'b0;
                                state_next = jpei_pkg::S_LK_SCAN;
                            end
                        end
                    endcase
                end
            end
            jpei_pkg::S_AP_COUNT:
            begin
                if (rd_valid)
                    need_next = need_reg + need_inc;
                idx_next = idx_reg + IW'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next = '0;
                    if (need_next > CW'(TABLE_SLOTS))
                    begin
                        res_status_next = jpei_pkg::ST_FULL;
                        state_next = jpei_pkg::S_EMIT;
                    end
                    else
                        state_next = jpei_pkg::S_AP_CLEAR;
                end
            end
            jpei_pkg::S_AP_CLEAR:
            begin
                idx_next = idx_reg + IW'(1);
                if (idx_reg == IDX_LAST)
                    state_next = jpei_pkg::S_AP_INSERT;
                if (rd_valid && ovl)
                begin
                    tw_seq = rd_seq;
                    if (left_part)
                    begin
                        tw_en = 1'b1;
                        tw_page = rd_page;
                        tw_span = 16'(cmd_reg.from - rd_page);
                        tw_journal = rd_journal;
                    end
                    else if (right_part)
                    begin
                        tw_en = 1'b1;
                        tw_page = cmd_reg.to[31:0];
                        tw_span = 16'(ee - cmd_reg.to);
                        tw_journal = rd_journal + (cmd_reg.to[31:0] - rd_page);
                    end
                    else
                        valid_next[idx_reg] = 1'b0;
                    // both ends survive: the upper piece needs a free slot
                    if (left_part && right_part)
                    begin
                        sp_page_next = cmd_reg.to[31:0];
                        sp_span_next = 16'(ee - cmd_reg.to);
                        sp_journal_next = rd_journal + (cmd_reg.to[31:0] - rd_page);
                        sp_seq_next = rd_seq;
                        sp_last_next = (idx_reg == IDX_LAST);
                        state_next = jpei_pkg::S_AP_SPLIT;
                    end
                end
            end
            jpei_pkg::S_AP_SPLIT:
            begin
                tw_en = 1'b1; tw_idx = free_idx;
                tw_page = sp_page_reg; tw_span = sp_span_reg;
                tw_journal = sp_journal_reg; tw_seq = sp_seq_reg;
                valid_next[free_idx] = 1'b1;
                state_next = sp_last_reg ? jpei_pkg::S_AP_INSERT : jpei_pkg::S_AP_CLEAR;
            end
            jpei_pkg::S_AP_INSERT:
            begin
                tw_en = 1'b1; tw_idx = free_idx;
                tw_page = cmd_reg.from; tw_span = cmd_reg.span;
                tw_journal = cmd_reg.jpage; tw_seq = cmd_reg.seq;
                valid_next[free_idx] = 1'b1;
                state_next = jpei_pkg::S_EMIT;
            end
            jpei_pkg::S_ER_SCAN:
            begin
                if (rd_valid && (rd_seq <= cmd_reg.seq))
                    valid_next[idx_reg] = 1'b0;
                idx_next = idx_reg + IW'(1);
                if (idx_reg == IDX_LAST)
                    state_next = jpei_pkg::S_EMIT;
            end
            jpei_pkg::S_LK_SCAN:
            begin
                if (cand)
                begin
                    found_next = 1'b1;
                    best_page_next = rd_page;
                    best_span_next = rd_span;
                    best_journal_next = rd_journal;
                end
                idx_next = idx_reg + IW'(1);
                if (idx_reg == IDX_LAST)
                    state_next = jpei_pkg::S_LK_ROUND;
            end
            jpei_pkg::S_LK_ROUND:
            begin
                idx_next = '0;
                res_status_next = jpei_pkg::ST_OK;
                res_hit_next = pend_reg;
                // a lookup without hits answers with zero mapping fields
                res_page_next = pend_reg ? pend_page_reg : '0;
                res_journal_next = pend_reg ? pend_journal_reg : '0;
                res_span_next = pend_reg ? pend_span_reg : '0;
                if (found_reg)
                begin
                    // hold this hit until we know whether another follows
                    pend_next = 1'b1;
                    pend_page_next = cf[31:0];
                    pend_span_next = 16'(ct - cf);
                    pend_journal_next = best_journal_reg + (cf[31:0] - best_page_reg);
                    last_pg_next = best_page_reg;
                    have_last_next = 1'b1;
                    found_next = 1'b0;
                    res_last_next = 1'b0;
                    ret_next = jpei_pkg::S_LK_SCAN;
                    state_next = pend_reg ? jpei_pkg::S_EMIT : jpei_pkg::S_LK_SCAN;
                end
                else
                begin
                    res_last_next = 1'b1;
                    ret_next = jpei_pkg::S_IDLE;
                    state_next = jpei_pkg::S_EMIT;
                end
            end
            jpei_pkg::S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    os_next = res_status_reg; oh_next = res_hit_reg;
                    op_next = res_page_reg; oj_next = res_journal_reg;
                    osp_next = res_span_reg; oi_next = iseq_reg;
                    ol_next = res_last_reg;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = jpei_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= jpei_pkg::S_IDLE;
            ret_reg    <= jpei_pkg::S_IDLE;
            valid_reg  <= '0;
            iseq_reg   <= '0;
            inside_reg <= 1'b0;
            acc_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            found_reg  <= 1'b0;
            have_last_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            valid_reg  <= valid_next;
            iseq_reg   <= iseq_next;
            inside_reg <= inside_next;
            acc_reg    <= acc_next;
            ov_reg     <= ov_next;
            found_reg  <= found_next;
            have_last_reg <= have_last_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;   idx_reg <= idx_next;   need_reg <= need_next;
        res_status_reg <= res_status_next; res_hit_reg <= res_hit_next;
        res_last_reg <= res_last_next;     res_page_reg <= res_page_next;
        res_journal_reg <= res_journal_next; res_span_reg <= res_span_next;
        os_reg <= os_next; oh_reg <= oh_next; ol_reg <= ol_next; op_reg <= op_next;
        oj_reg <= oj_next; osp_reg <= osp_next; oi_reg <= oi_next;
        sp_page_reg <= sp_page_next; sp_journal_reg <= sp_journal_next;
        sp_span_reg <= sp_span_next; sp_seq_reg <= sp_seq_next; sp_last_reg <= sp_last_next;
        last_pg_reg <= last_pg_next;
        best_page_reg <= best_page_next; best_journal_reg <= best_journal_next;
        best_span_reg <= best_span_next;
        pend_page_reg <= pend_page_next; pend_journal_reg <= pend_journal_next;
        pend_span_reg <= pend_span_next;
        if (tw_en)
        begin
            slot_page[tw_idx]    <= tw_page;
            slot_span[tw_idx]    <= tw_span;
            slot_journal[tw_idx] <= tw_journal;
            slot_seq[tw_idx]     <= tw_seq;
        end
    end

    assign out_valid        = ov_reg;
    assign status           = os_reg;
    assign hit              = oh_reg;
    assign hit_page         = op_reg;
    assign hit_journal_page = oj_reg;
    assign hit_span         = osp_reg;
    assign indexed_seq_num  = oi_reg;
    assign run_last         = ol_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/journal_page_extent_index.sv -----
// apply: a count scan, then a clear scan with a split step when an extent splits in two,
// then an insert; a full table ends after the count scan; rejected, empty or out-of-range
// applies and sets go straight to the result; erase: a scan; lookup: a scan per hit and a last scan
// throughput: one request at a time in the back end, bound by the one-slot-per-cycle scan
// and by any wait of a result on out_ready
// reset: asynchronous active-low rst_n empties the queue, clears slot valid bits and tracking
`timescale 1ns / 1ps
`default_nettype none

module journal_page_extent_index #(
    parameter int TABLE_SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request transactions
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [47:0] seq_num,
    input  wire logic [47:0] prev_seq_num,
    input  wire logic [31:0] page_start,
    input  wire logic [15:0] page_span,
    input  wire logic [31:0] journal_page,
    input  wire logic        record_end,
    // result transactions
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             hit,
    output logic [31:0]      hit_page,
    output logic [31:0]      hit_journal_page,
    output logic [15:0]      hit_span,
    output logic [47:0]      indexed_seq_num,
    output logic             run_last
);

    // queue between classification and execution
    logic           q_valid;
    logic           q_pop;
    jpei_pkg::cmd_t q_cmd;

    // front: takes transactions, computes range end and the bad-range flag
    jpei_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .seq_num      (seq_num),
        .prev_seq_num (prev_seq_num),
        .page_start   (page_start),
        .page_span    (page_span),
        .journal_page (journal_page),
        .record_end   (record_end),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    // back: extent table and slot scans; the result register decouples out_ready
    jpei_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_cmd            (q_cmd),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .hit              (hit),
        .hit_page         (hit_page),
        .hit_journal_page (hit_journal_page),
        .hit_span         (hit_span),
        .indexed_seq_num  (indexed_seq_num),
        .run_last         (run_last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/jpei_checker.sv -----
// jpei_checker: port-level checks on result transactions of the extent index,
// bound to journal_page_extent_index; uses jpei_pkg
`timescale 1ns / 1ps
`default_nettype none

module jpei_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic        hit,
    input wire logic [31:0] hit_page,
    input wire logic [31:0] hit_journal_page,
    input wire logic [15:0] hit_span,
    input wire logic        run_last
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a mapping result is always ok and never empty
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (status == jpei_pkg::ST_OK) && (hit_span != 16'd0))
        else $error("bad lookup mapping");

    // non-mapping results are single and carry zero mapping fields
    a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> run_last && (hit_page == 32'd0)
            && (hit_journal_page == 32'd0) && (hit_span == 16'd0))
        else $error("malformed non-mapping result");

    // after a handed-over mapping that does not end its run, an immediately offered mapping lies higher
    a_pages_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && hit && !run_last
            |=> !out_valid || !hit || (hit_page > $past(hit_page)))
        else $error("lookup mappings out of page order");

endmodule

bind journal_page_extent_index jpei_checker u_jpei_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .hit              (hit),
    .hit_page         (hit_page),
    .hit_journal_page (hit_journal_page),
    .hit_span         (hit_span),
    .run_last         (run_last)
);

`default_nettype wire
